// ===== rtl/core/update_gap_miss_counter_core_defines.svh =====
// assertion macros used by update_gap_miss_counter_core
`ifndef UPDATE_GAP_MISS_COUNTER_CORE_DEFINES_SVH
`define UPDATE_GAP_MISS_COUNTER_CORE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define UGMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// trigger in one cycle implies consequence in the next
`define UGMC_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/ugmc_pkg.sv =====
package ugmc_pkg;

  localparam int DATA_W     = 32;
  localparam int STAMP_BITS = 32;
  // only the low stamp bits take part, never more than the field width
  localparam int STAMP_W    = (STAMP_BITS < DATA_W) ? STAMP_BITS : DATA_W;
  localparam int SEC_W      = 23;

  // floor(x / 1000) = (x * RECIP) >> SEC_SHIFT, exact for every 32-bit x
  localparam int RECIP_W             = 29;
  localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
  localparam int SEC_SHIFT           = 38;
  localparam int PROD_W              = DATA_W + RECIP_W;

  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam int IN_DATA_W   = 32;
  localparam int OUT_PACK_W  = 3 * DATA_W + 2 * SEC_W;
  localparam int OUT_DATA_W  = ((OUT_PACK_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = 5;

  localparam int APB_AW = 5;
  localparam logic [APB_AW-1:0] ADDR_UPD_PERIOD      = 5'h00;
  localparam logic [APB_AW-1:0] ADDR_GAP_CHECK_EN    = 5'h04;
  localparam logic [APB_AW-1:0] ADDR_GAP_LIMIT       = 5'h08;
  localparam logic [APB_AW-1:0] ADDR_TOLERANCE_EN    = 5'h0c;
  localparam logic [APB_AW-1:0] ADDR_TOLERANCE       = 5'h10;

  localparam logic [DATA_W-1:0] RST_UPD_PERIOD      = 32'd1000;
  localparam logic [DATA_W-1:0] RST_GAP_LIMIT       = 32'd60000;

  typedef enum logic [2:0] {
    V_FIRST       = 3'd0,
    V_NOREF_BEGIN = 3'd1,
    V_NOREF_STILL = 3'd2,
    V_REF_BACK    = 3'd3,
    V_MAX_GAP     = 3'd4,
    V_MISS        = 3'd5,
    V_OK          = 3'd6
  } verdict_e;

  typedef struct packed {
    logic [DATA_W-1:0] upd_period;
    logic              gap_check_en;
    logic [DATA_W-1:0] gap_limit;
    logic              tolerance_en;
    logic [DATA_W-1:0] tolerance;
  } ugmc_cfg_t;

  typedef struct packed {
    logic ld_input;
    logic ld_diff;
    logic ld_class;
    logic ld_elapsed;
    logic ld_noref;
    logic div_start;
    logic commit;
  } ugmc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } ugmc_status_t;

  typedef struct packed {
    logic [SEC_W-1:0]  elapsed_seconds;
    logic [SEC_W-1:0]  noref_seconds;
    logic [DATA_W-1:0] gap_count;
    logic [DATA_W-1:0] miss_count;
    logic [DATA_W-1:0] interval_ms;
    logic              ref_flag;
    logic              interval_judged;
    verdict_e          verdict;
  } ugmc_result_t;

endpackage

// ===== rtl/core/ugmc_div.sv =====
module ugmc_div import ugmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              busy_o,
  output logic [DATA_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    dvs_q, dvs_d;
  logic [DATA_W:0]      trial;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      // a zero divisor counts as one
      dvs_d  = (divisor_i == '0) ? DATA_W'(1) : divisor_i;
    end else if (busy_q) begin
      if (!trial[DATA_W]) begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/ugmc_ctrl.sv =====
module ugmc_ctrl import ugmc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ugmc_status_t status_i,
  output ugmc_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_CLASS = 3'd2;
  localparam logic [2:0] S_NREF  = 3'd3;
  localparam logic [2:0] S_NSEC  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_input = 1'b1;
          state_d        = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.ld_diff = 1'b1;
        state_d       = S_CLASS;
      end
      S_CLASS: begin
        cmd_o.ld_class = 1'b1;
        state_d        = S_NREF;
      end
      S_NREF: begin
        cmd_o.ld_elapsed = 1'b1;
        state_d          = S_NSEC;
      end
      S_NSEC: begin
        cmd_o.ld_noref = 1'b1;
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/core/ugmc_dp.sv =====
module ugmc_dp import ugmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ugmc_cfg_t         cfg_i,
  input  ugmc_cmd_t         cmd_i,
  output ugmc_status_t      status_o,
  input  logic [DATA_W-1:0] in_stamp_i,
  input  logic              in_ref_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ugmc_result_t      out_result_o
);

  function automatic logic [DATA_W-1:0] diff_or_zero(input logic [STAMP_W-1:0] later,
                                                     input logic [STAMP_W-1:0] earlier);
    logic [STAMP_W-1:0] d;
    d = (later >= earlier) ? (later - earlier) : '0;
    return DATA_W'(d);
  endfunction

  // architectural state
  logic               started_q, in_noref_q;
  logic [STAMP_W-1:0] first_q, prev_q, nr_start_q;
  logic [DATA_W-1:0]  miss_q, gap_q;
  logic [SEC_W-1:0]   nr_secs_q;

  // per-word work registers
  logic [STAMP_W-1:0] stamp_q;
  logic               ref_q;
  logic [DATA_W-1:0]  el_diff_q, nr_diff_q, d_q;
  verdict_e           verdict_q, verdict_d;
  logic [PROD_W-1:0]  prod_q;
  logic [SEC_W-1:0]   elapsed_q, nr_new_q;

  logic               out_valid_q;
  ugmc_result_t       out_q, out_d;

  logic [DATA_W:0]    thresh;
  logic [DATA_W-1:0]  mul_a;
  logic [DATA_W-1:0]  quotient;
  logic               div_busy;
  logic [DATA_W-1:0]  acc_old;
  logic [DATA_W:0]    acc_sum;
  logic [DATA_W-1:0]  acc_new;
  logic               judged;

  ugmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (d_q),
    .divisor_i  (cfg_i.upd_period),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign thresh = {1'b0, cfg_i.upd_period} +
                  (cfg_i.tolerance_en ? {1'b0, cfg_i.tolerance} : '0);

  always_comb begin
    if (!started_q) begin
      verdict_d = V_FIRST;
    end else if (!ref_q) begin
      verdict_d = in_noref_q ? V_NOREF_STILL : V_NOREF_BEGIN;
    end else if (in_noref_q) begin
      verdict_d = V_REF_BACK;
    end else if (cfg_i.gap_check_en && (d_q > cfg_i.gap_limit)) begin
      verdict_d = V_MAX_GAP;
    end else if ({1'b0, d_q} > thresh) begin
      verdict_d = V_MISS;
    end else begin
      verdict_d = V_OK;
    end
  end

  // the one multiplier serves elapsed and no-reference seconds in turn
  assign mul_a = cmd_i.ld_class ? el_diff_q : nr_diff_q;

  assign acc_old = (verdict_q == V_MAX_GAP) ? gap_q : miss_q;
  assign acc_sum = {1'b0, acc_old} + {1'b0, quotient};
  assign acc_new = acc_sum[DATA_W] ? '1 : acc_sum[DATA_W-1:0];
  assign judged  = (verdict_q == V_MAX_GAP) || (verdict_q == V_MISS) || (verdict_q == V_OK);

  always_comb begin
    out_d                 = '0;
    out_d.verdict         = verdict_q;
    out_d.interval_judged = judged;
    out_d.interval_ms     = judged ? d_q : '0;
    out_d.ref_flag        = ref_q;
    out_d.miss_count      = (verdict_q == V_MISS) ? acc_new : miss_q;
    out_d.gap_count       = (verdict_q == V_MAX_GAP) ? acc_new : gap_q;
    out_d.noref_seconds   = (verdict_q == V_REF_BACK) ? nr_new_q : nr_secs_q;
    out_d.elapsed_seconds = elapsed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      in_noref_q  <= 1'b0;
      first_q     <= '0;
      prev_q      <= '0;
      nr_start_q  <= '0;
      miss_q      <= '0;
      gap_q       <= '0;
      nr_secs_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        prev_q      <= stamp_q;
        case (verdict_q)
          V_FIRST: begin
            started_q <= 1'b1;
            first_q   <= stamp_q;
          end
          V_NOREF_BEGIN: begin
            in_noref_q <= 1'b1;
            nr_start_q <= stamp_q;
          end
          V_NOREF_STILL: begin
            in_noref_q <= 1'b1;
          end
          V_REF_BACK: begin
            in_noref_q <= 1'b0;
            nr_start_q <= '0;
            nr_secs_q  <= nr_new_q;
          end
          V_MAX_GAP: begin
            gap_q <= acc_new;
          end
          V_MISS: begin
            miss_q <= acc_new;
          end
          default: begin
          end
        endcase
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_input) begin
      stamp_q <= in_stamp_i[STAMP_W-1:0];
      ref_q   <= in_ref_i;
    end
    if (cmd_i.ld_diff) begin
      // the first word is its own origin, so its elapsed time is zero
      el_diff_q <= started_q ? diff_or_zero(stamp_q, first_q) : '0;
      nr_diff_q <= diff_or_zero(stamp_q, nr_start_q);
      d_q       <= diff_or_zero(stamp_q, prev_q);
    end
    if (cmd_i.ld_class) begin
      verdict_q <= verdict_d;
    end
    prod_q <= PROD_W'(mul_a) * PROD_W'(RECIP);
    // the quotient is below 2^23, no clamp needed
    if (cmd_i.ld_elapsed) begin
      elapsed_q <= prod_q[SEC_SHIFT +: SEC_W];
    end
    if (cmd_i.ld_noref) begin
      nr_new_q <= prod_q[SEC_SHIFT +: SEC_W];
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign status_o.need_div = (verdict_q == V_MAX_GAP) || (verdict_q == V_MISS);
  assign status_o.div_busy = div_busy;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule

// ===== rtl/core/update_gap_miss_counter_core.sv =====
// a word passes load, differences, classification, elapsed and no-reference seconds,
// a 32-step divide by the update interval for a maximum gap or a miss, and commit,
// which waits until the output register is free; the next word is taken only after
// commit, while the previous result may still wait in the output register
// reset: asynchronous, active low; clears counters, history and the config registers
// to their defaults (update interval 1000 ms, gap limit 60000 ms, checks off)
`include "update_gap_miss_counter_core_defines.svh"

module update_gap_miss_counter_core import ugmc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input words
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // stamp_ms[31:0]
  input  logic [0:0]             s_axis_tuser,   // ref_present[0]
  // result words
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // interval_ms[31:0], miss_count[63:32], gap_count[95:64],
  // noref_seconds[118:96], elapsed_seconds[141:119], zero fill above
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // verdict[2:0], interval_judged[3], ref_flag[4]
  output logic [OUT_USER_W-1:0]  m_axis_tuser,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  ugmc_cfg_t    cfg_q;
  ugmc_cmd_t    cmd;
  ugmc_status_t status;
  ugmc_result_t result;
  logic         wr_en;
  logic         verdict_judged;

  // register file; write it only while no word is in flight, the block does not enforce this
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upd_period      <= RST_UPD_PERIOD;
      cfg_q.gap_check_en    <= 1'b0;
      cfg_q.gap_limit       <= RST_GAP_LIMIT;
      cfg_q.tolerance_en    <= 1'b0;
      cfg_q.tolerance       <= '0;
    end else if (wr_en) begin
      case (paddr)
        ADDR_UPD_PERIOD:      cfg_q.upd_period      <= pwdata;
        ADDR_GAP_CHECK_EN:    cfg_q.gap_check_en    <= pwdata[0];
        ADDR_GAP_LIMIT:       cfg_q.gap_limit       <= pwdata;
        ADDR_TOLERANCE_EN:    cfg_q.tolerance_en    <= pwdata[0];
        ADDR_TOLERANCE:       cfg_q.tolerance       <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr)
      ADDR_UPD_PERIOD:      prdata = cfg_q.upd_period;
      ADDR_GAP_CHECK_EN:    prdata = DATA_W'(cfg_q.gap_check_en);
      ADDR_GAP_LIMIT:       prdata = cfg_q.gap_limit;
      ADDR_TOLERANCE_EN:    prdata = DATA_W'(cfg_q.tolerance_en);
      ADDR_TOLERANCE:       prdata = cfg_q.tolerance;
      default:              prdata = '0;
    endcase
  end

  // sequencer: load, differences, classify, seconds, optional divide, commit
  ugmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // history, counters, seconds multiplier, divider and output register
  ugmc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_stamp_i   (s_axis_tdata),
    .in_ref_i     (s_axis_tuser[0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result)
  );

  // pack the result word, first field lowest
  assign m_axis_tdata = {{(OUT_DATA_W - OUT_PACK_W){1'b0}},
                         result.elapsed_seconds,
                         result.noref_seconds,
                         result.gap_count,
                         result.miss_count,
                         result.interval_ms};
  assign m_axis_tuser = {result.ref_flag, result.interval_judged, result.verdict};

  // verdict classes that carry an assessed interval
  assign verdict_judged = (m_axis_tuser[2:0] == V_MAX_GAP) || (m_axis_tuser[2:0] == V_MISS) ||
                          (m_axis_tuser[2:0] == V_OK);

  // one word in work at a time
  `UGMC_ASSERT_NEXT(a_one_word_in_work, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // judged flag agrees with the verdict class
  `UGMC_ASSERT(a_judged_matches_verdict, m_axis_tvalid |-> (m_axis_tuser[3] == verdict_judged))
  // an unjudged word carries a zero interval
  `UGMC_ASSERT(a_unjudged_zero, (m_axis_tvalid && !m_axis_tuser[3]) |-> (result.interval_ms == '0))

endmodule
